// ----- hdl/lookahead_noise_gate_assert.svh -----
// Assertion macros for the lookahead noise gate.
`ifndef LOOKAHEAD_NOISE_GATE_ASSERT_SVH
`define LOOKAHEAD_NOISE_GATE_ASSERT_SVH
`ifndef SYNTHESIS
`define LNG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define LNG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LNG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LNG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hdl/lng_pkg.sv -----
// Package: types, constants and codes of the lookahead noise gate.
package lng_pkg;
    localparam int DELAY_DEPTH = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int AW          = $clog2(DELAY_DEPTH);
    localparam int SUM_BITS    = 2 * SAMPLE_BITS + 12;
    localparam int MA          = (2 * SAMPLE_BITS - 1 > 18) ? 2 * SAMPLE_BITS - 1 : 18;
    localparam int MB          = (SAMPLE_BITS + 2 > 18) ? SAMPLE_BITS + 2 : 18;
    localparam int MP          = MA + MB;
    localparam int EL_BITS     = 18;
    localparam logic [EL_BITS-1:0] ELAPSED_MAX = '1;
    localparam logic [15:0] UNITY = 16'h8000;

    typedef enum logic [2:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_FLOOR     = 3'd1,
        CFG_ATTACK    = 3'd2,
        CFG_RELEASE   = 3'd3,
        CFG_HOLD      = 3'd4,
        CFG_DELAY     = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_WR, S_OL, S_OR, S_TT, S_TD,
        S_CMP, S_SPAN, S_DIVLD, S_DIV, S_GL, S_GR, S_DONE
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] in_left;
        logic signed [SAMPLE_BITS-1:0] in_right;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
        logic                          gate_is_open;
    } t_out;
endpackage

// ----- hdl/lng_ram.sv -----
// Single-port delay line memory with registered read data.
module lng_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [0:(1 << ADDR_W) - 1];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/lng_mul.sv -----
// Shared signed multiplier with registered product.
module lng_mul (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [lng_pkg::MA-1:0]    i_a,
    input  logic signed [lng_pkg::MB-1:0]    i_b,
    output logic signed [lng_pkg::MP-1:0]    o_p
);
    import lng_pkg::*;
    logic signed [MP-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= MP'(i_a) * MP'(i_b);
        end
    end

    assign o_p = r_p;
endmodule

// ----- hdl/lng_div.sv -----
// Restoring divider, one quotient bit per cycle, 32 by 16 bits.
module lng_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [15:0] o_quot
);
    logic [16:0] r_rem;
    logic [15:0] r_quo;
    logic [15:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] trial;
    logic        fit;

    assign trial = {r_rem[15:0], r_quo[15]};
    assign fit   = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend[31:16]};
            r_quo <= i_dividend[15:0];
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fit ? trial - {1'b0, r_den} : trial;
            r_quo <= {r_quo[14:0], fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// ----- hdl/lookahead_noise_gate.sv -----
// Top level: sequencer of the lookahead noise gate around shared multiplier and divider.
// Usage:
//   Input channel i_in_valid/o_in_ready/i_in_data carries one stereo pair per item.
//   Output channel o_out_valid/i_out_ready/o_out_data returns one item per input:
//   the pair stored delay_length items earlier times the gate gain, plus the open flag.
//   Config channel i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data writes registers
//   (threshold, floor, attack, release, hold, delay); write only while idle.
// Sequence: each accepted item passes RD, WR, OL, OR, TT, TD, CMP, SPAN, GL, GR, DONE;
//   when the gain is on an attack or release ramp, DIVLD and DIV (16-step divider) follow SPAN.
//   The next item is accepted on the cycle after the result is loaded; the shared
//   multiplier is used eight or nine times an item.
// Reset: synchronous, active low. Afterwards the delay memory is cleared one entry
//   per cycle, all 4096 entries, during which no item is accepted; config writes
//   are taken at once. The gate starts open with elapsed count saturated.
// Stall: a result waits in the output register; the sequencer holds its last
//   stage until the register frees, and input ready stays low meanwhile.
`include "lookahead_noise_gate_assert.svh"
module lookahead_noise_gate (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lng_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lng_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);
    import lng_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam logic signed [SB-1:0] S_HI = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_LO = {1'b1, {(SB-1){1'b0}}};

    t_state r_state, n_state;

    logic [14:0] r_thr;
    logic [15:0] r_floor, r_attack, r_release, r_hold;
    logic [11:0] r_delay;

    logic [AW-1:0] r_wp, r_clr, r_idx, r_d;
    logic signed [SB-1:0] r_l, r_r, r_ol, r_or;
    logic [2*SB-1:0] r_nl, r_nr;
    logic [SUM_BITS-1:0] r_sl, r_sr;
    logic r_open, r_above, r_need_div;
    logic [EL_BITS-1:0] r_elapsed;
    logic [15:0] r_gain, r_num, r_den;
    logic signed [SB-1:0] r_ql;
    t_out r_out;
    logic r_out_valid;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [2*SB-1:0] ram_wdata, ram_rdata;
    logic mul_en;
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [MP-1:0] mul_p;
    logic div_start, div_done;
    logic [15:0] div_q;

    logic [15:0] fl, span;
    logic [SB-2:0] thr_s;
    logic [SB+14-1:0] thr_w;
    logic [16:0] d_w;
    logic [AW-1:0] d_cl;
    logic [SUM_BITS-1:0] limit;
    logic above;
    logic [EL_BITS-1:0] e_cur, e_rel;
    logic out_free;
    logic signed [SB-1:0] sat_p;

    function automatic logic [SUM_BITS-1:0] upd_sum(input logic [SUM_BITS-1:0] s,
                                                    input logic [2*SB-1:0] o,
                                                    input logic [2*SB-1:0] n);
        logic [SUM_BITS-1:0] base;
        logic [SUM_BITS:0]   t;
        base = (s >= SUM_BITS'(o)) ? s - SUM_BITS'(o) : '0;
        t = {1'b0, base} + (SUM_BITS + 1)'(n);
        return t[SUM_BITS] ? '1 : t[SUM_BITS-1:0];
    endfunction

    function automatic logic signed [SB-1:0] sat_gain(input logic signed [MP-1:0] p);
        logic signed [MP-1:0] t;
        logic signed [MP-1:0] q;
        t = p + MP'(16384);
        q = t >>> 15;
        if (q > MP'(S_HI)) return S_HI;
        if (q < MP'(S_LO)) return S_LO;
        return q[SB-1:0];
    endfunction

    assign fl   = (r_floor > UNITY) ? UNITY : r_floor;
    assign span = UNITY - fl;
    assign thr_w = {r_thr, {(SB-1){1'b0}}} >> 15;
    assign thr_s = thr_w[SB-2:0];
    assign d_w  = (r_delay == 12'd0) ? 17'd1 :
                  ({5'd0, r_delay} > 17'(DELAY_DEPTH - 1)) ? 17'(DELAY_DEPTH - 1) :
                  {5'd0, r_delay};
    assign d_cl = d_w[AW-1:0];
    assign limit = SUM_BITS'(mul_p[2*(SB-1)+11:0]);
    assign above = (r_sl > limit) || (r_sr > limit);
    assign e_cur = (above != r_open) ? '0 : r_elapsed;
    assign e_rel = e_cur - EL_BITS'(r_hold);
    assign out_free = !r_out_valid || i_out_ready;
    assign sat_p = sat_gain(mul_p);

    lng_ram #(.ADDR_W(AW), .DATA_W(2 * SB)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    lng_mul u_mul (
        .i_clk(i_clk), .i_en(mul_en), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p)
    );

    lng_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(mul_p[31:0]), .i_divisor(r_den),
        .o_done(div_done), .o_quot(div_q)
    );

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_addr  = r_idx;
        ram_wdata = {r_r, r_l};
        mul_en    = 1'b1;
        mul_a     = MA'(r_or);
        mul_b     = MB'(r_or);
        div_start = 1'b0;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = '0;
                mul_en    = 1'b0;
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                mul_en = 1'b0;
                if (i_in_valid) n_state = S_RD;
            end
            S_RD: begin
                mul_a   = MA'(r_l);
                mul_b   = MB'(r_l);
                n_state = S_WR;
            end
            S_WR: begin
                ram_we   = 1'b1;
                ram_addr = r_wp;
                mul_a    = MA'(r_r);
                mul_b    = MB'(r_r);
                n_state  = S_OL;
            end
            S_OL: begin
                mul_a   = MA'(r_ol);
                mul_b   = MB'(r_ol);
                n_state = S_OR;
            end
            S_OR: begin
                n_state = S_TT;
            end
            S_TT: begin
                mul_a   = MA'({1'b0, thr_s});
                mul_b   = MB'({1'b0, thr_s});
                n_state = S_TD;
            end
            S_TD: begin
                mul_a   = MA'(mul_p[2*(SB-1)-1:0]);
                mul_b   = MB'(d_w);
                n_state = S_CMP;
            end
            S_CMP: begin
                mul_en  = 1'b0;
                n_state = S_SPAN;
            end
            S_SPAN: begin
                mul_a   = MA'({1'b0, span});
                mul_b   = MB'({1'b0, r_num});
                mul_en  = r_need_div;
                n_state = r_need_div ? S_DIVLD : S_GL;
            end
            S_DIVLD: begin
                mul_en    = 1'b0;
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                mul_en = 1'b0;
                if (div_done) n_state = S_GL;
            end
            S_GL: begin
                mul_a   = MA'(r_ol);
                mul_b   = MB'({1'b0, r_gain});
                n_state = S_GR;
            end
            S_GR: begin
                mul_a   = MA'(r_or);
                mul_b   = MB'({1'b0, r_gain});
                n_state = S_DONE;
            end
            S_DONE: begin
                mul_en = 1'b0;
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_wp        <= '0;
            r_sl        <= '0;
            r_sr        <= '0;
            r_open      <= 1'b1;
            r_elapsed   <= ELAPSED_MAX;
            r_out_valid <= 1'b0;
            r_thr       <= 15'd16423;
            r_floor     <= 16'd37;
            r_attack    <= 16'd48;
            r_release   <= 16'd48;
            r_hold      <= 16'd480;
            r_delay     <= 12'd1008;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_THRESHOLD: r_thr     <= i_cfg_data[14:0];
                    CFG_FLOOR:     r_floor   <= i_cfg_data;
                    CFG_ATTACK:    r_attack  <= i_cfg_data;
                    CFG_RELEASE:   r_release <= i_cfg_data;
                    CFG_HOLD:      r_hold    <= i_cfg_data;
                    CFG_DELAY:     r_delay   <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (r_state == S_WR) r_wp <= r_wp + 1'b1;
            if (r_state == S_OR) r_sl <= upd_sum(r_sl, mul_p[2*SB-1:0], r_nl);
            if (r_state == S_TT) r_sr <= upd_sum(r_sr, mul_p[2*SB-1:0], r_nr);
            if (r_state == S_CMP) begin
                r_open    <= above;
                r_elapsed <= (e_cur == ELAPSED_MAX) ? ELAPSED_MAX : e_cur + 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_l   <= i_in_data.in_left;
                r_r   <= i_in_data.in_right;
                r_d   <= d_cl;
                r_idx <= r_wp - d_cl;
            end
            S_WR: begin
                r_nl <= mul_p[2*SB-1:0];
                r_ol <= ram_rdata[SB-1:0];
                r_or <= ram_rdata[2*SB-1:SB];
            end
            S_OL: r_nr <= mul_p[2*SB-1:0];
            S_CMP: begin
                r_above    <= above;
                r_need_div <= 1'b0;
                r_gain     <= UNITY;
                r_num      <= e_cur[15:0];
                r_den      <= r_attack;
                if (above) begin
                    if (e_cur < EL_BITS'(r_attack)) r_need_div <= 1'b1;
                end else if (e_cur >= EL_BITS'(r_hold)) begin
                    if (e_rel < EL_BITS'(r_release)) begin
                        r_need_div <= 1'b1;
                        r_num      <= r_release - e_rel[15:0];
                        r_den      <= r_release;
                    end else begin
                        r_gain <= fl;
                    end
                end
            end
            S_SPAN: if (r_need_div) r_gain <= fl;
            S_DIV: if (div_done) r_gain <= fl + div_q;
            S_GR: r_ql <= sat_p;
            S_DONE: begin
                if (out_free) begin
                    r_out.out_left     <= r_ql;
                    r_out.out_right    <= sat_p;
                    r_out.gate_is_open <= r_above;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `LNG_ASSERT_IMP(a_clear_busy, i_clk, i_rst_n, r_state == S_CLEAR, !o_in_ready, "item accepted during clear")
    `LNG_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "back to back accept")
    `LNG_ASSERT_IMP(a_gain_max, i_clk, i_rst_n, r_state == S_GL, r_gain <= UNITY, "gain above unity")
    `LNG_ASSERT_IMP(a_delay_pos, i_clk, i_rst_n, r_state == S_RD, r_d != '0 && r_idx != r_wp, "read hits write slot")
endmodule

// ----- dv/lng_gate_checker.sv -----
// Checker for the lookahead noise gate: predicts each output item and compares it.
module lng_gate_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  lng_pkg::t_in   i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  lng_pkg::t_out  i_out_data,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    output int             o_fail_count,
    output int             o_pending
);
    import lng_pkg::*;

    logic [2*SAMPLE_BITS-1:0] pair_line [DELAY_DEPTH];
    logic [AW-1:0]            wr_ptr;
    logic [SUM_BITS-1:0]      left_energy, right_energy;
    bit                       gate_open;
    logic [EL_BITS-1:0]       elapsed;
    logic [14:0]              thresh_q;
    logic [15:0]              floor_q, attack_q, release_q, hold_q;
    logic [11:0]              delay_q;
    t_out                     gated_pairs [$];

    initial o_fail_count = 0;
    initial o_pending = 0;

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    function automatic logic [SUM_BITS-1:0] slide_energy(logic [SUM_BITS-1:0] acc,
            logic signed [15:0] leaving, logic signed [15:0] entering);
        longint s, o, n;
        s = longint'(acc);
        o = longint'(leaving) * longint'(leaving);
        n = longint'(entering) * longint'(entering);
        s = (s >= o) ? s - o : 0;
        s = s + n;
        if (s > (64'sd1 <<< SUM_BITS) - 1)
            s = (64'sd1 <<< SUM_BITS) - 1;
        return s[SUM_BITS-1:0];
    endfunction

    function automatic logic signed [15:0] scale(logic signed [15:0] s, longint g);
        longint t;
        t = (longint'(s) * g + 16384) >>> 15;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return t[15:0];
    endfunction

    task automatic predict_pair(t_in d);
        logic [AW-1:0]      rd_ptr;
        logic [31:0]        old;
        longint             win, thr, limit, fl, span, g, e;
        bit                 above;
        t_out               r;
        win = (delay_q == 0) ? 1 : delay_q;
        pair_line[wr_ptr] = {d.in_right, d.in_left};
        rd_ptr = wr_ptr - AW'(win);
        old = pair_line[rd_ptr];
        wr_ptr = wr_ptr + 1'b1;
        left_energy = slide_energy(left_energy, old[15:0], d.in_left);
        right_energy = slide_energy(right_energy, old[31:16], d.in_right);
        thr = thresh_q;
        limit = thr * thr * win;
        above = (longint'(left_energy) > limit) || (longint'(right_energy) > limit);
        fl = (floor_q > 16'h8000) ? 32768 : floor_q;
        span = 32768 - fl;
        if (above != gate_open) begin
            gate_open = above;
            elapsed = '0;
        end
        e = elapsed;
        if (above) begin
            g = (e < attack_q) ? fl + (span * e) / attack_q : 32768;
        end else if (e < hold_q) begin
            g = 32768;
        end else if (e - hold_q < release_q) begin
            g = fl + (span * (release_q - (e - hold_q))) / release_q;
        end else begin
            g = fl;
        end
        if (elapsed != ELAPSED_MAX)
            elapsed = elapsed + 1'b1;
        r.out_left = scale(old[15:0], g);
        r.out_right = scale(old[31:16], g);
        r.gate_is_open = above;
        gated_pairs.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            foreach (pair_line[k]) pair_line[k] = '0;
            wr_ptr = '0;
            left_energy = '0;
            right_energy = '0;
            gate_open = 1'b1;
            elapsed = ELAPSED_MAX;
            thresh_q = 15'd16423;
            floor_q = 16'd37;
            attack_q = 16'd48;
            release_q = 16'd48;
            hold_q = 16'd480;
            delay_q = 12'd1008;
            gated_pairs.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_THRESHOLD: thresh_q = i_cfg_data[14:0];
                    CFG_FLOOR:     floor_q = i_cfg_data;
                    CFG_ATTACK:    attack_q = i_cfg_data;
                    CFG_RELEASE:   release_q = i_cfg_data;
                    CFG_HOLD:      hold_q = i_cfg_data;
                    CFG_DELAY:     delay_q = i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_pair(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (gated_pairs.size() == 0) begin
                    report("unexpected item", 0, 0);
                end else begin
                    want = gated_pairs.pop_front();
                    if (i_out_data.out_left !== want.out_left)
                        report("out_left", i_out_data.out_left, want.out_left);
                    if (i_out_data.out_right !== want.out_right)
                        report("out_right", i_out_data.out_right, want.out_right);
                    if (i_out_data.gate_is_open !== want.gate_is_open)
                        report("gate_is_open", i_out_data.gate_is_open, want.gate_is_open);
                end
            end
        end
        o_pending = gated_pairs.size();
    end
endmodule

// ----- dv/lookahead_noise_gate_tb.sv -----
// Testbench top for the lookahead noise gate: stimulus, flow control and verdict.
module lookahead_noise_gate_tb;
    import lng_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in         in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out        out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          hold_req = 0;
    int          thr_now;

    lookahead_noise_gate i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    lng_gate_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #4000000;
        $display("lookahead_noise_gate regression: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random ready, long hold-off on request
    initial begin
        int seen;
        int n;
        seen = 0;
        @(posedge clk);
        forever begin
            if (seen != hold_req) begin
                seen = hold_req;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end else if ($urandom_range(0, 1)) begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end else begin
                out_ready <= 1'b0;
                n = pick_gap();
                repeat (n == 0 ? 1 : n) @(posedge clk);
            end
        end
    end

    task automatic send_pair(logic signed [15:0] l, logic signed [15:0] r);
        int gap;
        in_valid <= 1'b1;
        in_data <= '{in_left: l, in_right: r};
        do @(posedge clk); while (!in_ready);
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_regs(int thr, int fl, int att, int rel, int hld, int dly);
        int vals [6];
        vals = '{thr, fl, att, rel, hld, dly};
        thr_now = thr;
        for (int k = 0; k < 6; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(k);
            cfg_data <= 16'(vals[k]);
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic logic signed [15:0] level_sample(int mode);
        int amp;
        case (mode)
            0: amp = $urandom_range(0, 64);
            1: amp = 32767;
            2: return 16'($urandom);
            default: amp = thr_now + 16;
        endcase
        if (amp > 32767) amp = 32767;
        return 16'($urandom_range(0, 2 * amp) - amp);
    endfunction

    task automatic noisy_bursts(int count, int seg_max);
        int mode;
        int seg;
        while (count > 0) begin
            mode = $urandom_range(0, 3);
            seg = $urandom_range(1, seg_max);
            for (int k = 0; k < seg && count > 0; k++) begin
                send_pair(level_sample(mode), level_sample(mode));
                count--;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, open, attack, hold, release, floor
        set_regs(8000, 0, 3, 3, 2, 4);
        send_pair(16'sh7fff, -16'sh8000);
        send_pair(-16'sh8000, 16'sh7fff);
        send_pair(16'sh7fff, 16'sh7fff);
        send_pair(-16'sh8000, -16'sh8000);
        for (int k = 0; k < 6; k++) send_pair(16'sh7fff, -16'sh8000);
        for (int k = 0; k < 10; k++) send_pair(16'sh0001, -16'sh0001);
        send_pair(16'sh5555, -16'sh5556);
        send_pair(-16'sh2aab, 16'sh2aaa);
        send_pair(16'sh0000, 16'sh0000);
        send_pair(-16'sh0001, 16'sh0000);
        drain();

        set_regs(6000, 1000, 20, 30, 10, 16);
        noisy_bursts(300, 60);
        drain();
        set_regs(32767, 32768, 65535, 65535, 65535, 4095);
        noisy_bursts(200, 120);
        drain();
        set_regs(0, 65535, 0, 0, 0, 0);
        noisy_bursts(250, 20);
        drain();
        set_regs(12000, 200, 1, 1, 0, 1);
        noisy_bursts(300, 12);
        drain();
        set_regs(4000, 16384, 100, 200, 50, 64);
        noisy_bursts(400, 250);
        drain();
        set_regs(20000, 32767, 7, 5, 3, 2048);
        noisy_bursts(300, 100);
        drain();
        set_regs(10000, 37, 48, 48, 480, 200);
        hold_req = hold_req + 1;
        noisy_bursts(300, 300);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("lookahead_noise_gate regression: pass");
        end else begin
            $display("lookahead_noise_gate regression: fail");
        end
        $finish;
    end
endmodule
